/* sv/pdd_pkg.sv */
// Shared types and constants for the permutation diagonal discrepancy block.
// No dependencies; imported by the controller, the datapath and the top level.
package pdd_pkg;

    localparam int POS_W         = 10;   // position / value / split point width
    localparam int ORDER_W       = 11;   // order size width
    localparam int DEV_W         = 21;   // reported deviation width
    localparam int ACC_W         = 22;   // internal count*n and j*h width
    localparam int EPOCH_W       = 8;    // presence tag width, tag 0 never valid
    localparam int DATA_W        = 32;   // tdata width on both sides
    localparam int MAX_ORDER_DEF = 1024;

    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(3);
    localparam logic [DEV_W-1:0]   DEV_MAX     = {DEV_W{1'b1}};

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef struct packed {
        logic take;          // request accepted this cycle, latch it
        logic sweep_en;      // write one table entry with the null tag
        logic epoch_restart; // tag back to 1 after a sweep
        logic epoch_step;    // next tag: drops every presence mark
        logic lwrite_force;  // store the latched element without comparing positions
        logic lread;         // read the entry of the latched element
        logic lwrite_cond;   // store if absent or at a lower position
        logic eread;         // read the next value of an evaluation
        logic out_load;      // move the result into the output register
    } pdd_cmd_t;

    typedef struct packed {
        logic in_kind;       // kind of the request on the input
        logic in_pos_zero;   // load request at position zero
        logic short_order;   // order size below 3
        logic epoch_full;    // tag at its last code
        logic sweep_last;    // sweep at the last entry
        logic eval_last;     // last value of the evaluation being read
        logic out_busy;      // output register holds a result not yet taken
    } pdd_status_t;

endpackage

/* sv/pdd_ctrl.sv */
// Controller state machine of the permutation diagonal discrepancy block.
// Depends on pdd_pkg; drives the datapath through pdd_cmd_t.
module pdd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  pdd_pkg::pdd_status_t status,
    output pdd_pkg::pdd_cmd_t    cmd
);
    import pdd_pkg::*;

    localparam logic [3:0] ST_INIT    = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_WRAP    = 4'd2;
    localparam logic [3:0] ST_LWRITE  = 4'd3;
    localparam logic [3:0] ST_LREAD   = 4'd4;
    localparam logic [3:0] ST_LCMP    = 4'd5;
    localparam logic [3:0] ST_EREAD   = 4'd6;
    localparam logic [3:0] ST_EDRAIN1 = 4'd7;
    localparam logic [3:0] ST_EDRAIN2 = 4'd8;
    localparam logic [3:0] ST_DONE    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT, ST_WRAP:
            begin
                cmd.sweep_en = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.epoch_restart = 1'b1;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_LWRITE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take = 1'b1;
                    if (status.in_kind == KIND_EVAL)
                        state_next = status.short_order ? ST_DONE : ST_EREAD;
                    else if (!status.in_pos_zero)
                        state_next = ST_LREAD;
                    else if (status.epoch_full)
                        state_next = ST_WRAP;   // tags used up: wipe the table
                    else
                    begin
                        cmd.epoch_step = 1'b1;
                        state_next = ST_LWRITE;
                    end
                end
            end
            ST_LWRITE:
            begin
                cmd.lwrite_force = 1'b1;
                state_next = ST_IDLE;
            end
            ST_LREAD:
            begin
                cmd.lread = 1'b1;
                state_next = ST_LCMP;
            end
            ST_LCMP:
            begin
                cmd.lwrite_cond = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EREAD:
            begin
                cmd.eread = 1'b1;
                if (status.eval_last)
                    state_next = ST_EDRAIN1;
            end
            ST_EDRAIN1: state_next = ST_EDRAIN2;
            ST_EDRAIN2: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/pdd_datapath.sv */
// Datapath: value-to-position table with presence tags, evaluation pipeline,
// order size register and output register. Depends on pdd_pkg.
module pdd_datapath #(
    parameter int MAX_ORDER = pdd_pkg::MAX_ORDER_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pdd_pkg::DATA_W-1:0]    s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pdd_pkg::DATA_W-1:0]    m_tdata,
    input  logic                          cfg_we,
    input  logic [pdd_pkg::ORDER_W-1:0]   cfg_data,
    input  pdd_pkg::pdd_cmd_t             cmd,
    output pdd_pkg::pdd_status_t          status
);
    import pdd_pkg::*;

    localparam int AW     = $clog2(MAX_ORDER);
    localparam int WORD_W = EPOCH_W + POS_W;

    // table: {tag, position}; an entry is present when its tag matches epoch
    logic [WORD_W-1:0] mem [MAX_ORDER];
    logic [WORD_W-1:0] rd_q;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en;

    logic [ORDER_W-1:0] n_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [AW-1:0]      sweep_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   val_reg;
    logic [POS_W-1:0]   h_reg;

    logic [ORDER_W-1:0] k_reg;
    logic               d1_valid_reg;
    logic [ORDER_W-1:0] d1_k_reg;
    logic               d1_oor_reg;
    logic [ACC_W-1:0]   a_reg;
    logic [ACC_W-1:0]   b_reg;
    logic               e_valid_reg;
    logic [ACC_W-1:0]   e_a_reg;
    logic [ACC_W-1:0]   e_b_reg;
    logic [ORDER_W-1:0] e_j_reg;
    logic [ACC_W-1:0]   best_reg;
    logic [ORDER_W-1:0] best_j_reg;
    logic               missing_reg;

    logic               out_valid_reg;
    logic [POS_W-1:0]   out_j_reg;
    logic [DEV_W-1:0]   out_dev_reg;
    logic               out_missing_reg;

    logic [EPOCH_W-1:0] rd_tag;
    logic [POS_W-1:0]   rd_pos;
    logic               stored_hit;
    logic               val_ok;
    logic               present;
    logic               below_h;
    logic [ACC_W-1:0]   a_next;
    logic [ACC_W-1:0]   diff;

    assign rd_tag     = rd_q[WORD_W-1:POS_W];
    assign rd_pos     = rd_q[POS_W-1:0];
    assign stored_hit = (rd_tag == epoch_reg);
    assign val_ok     = (32'(val_reg) < MAX_ORDER);

    assign status.in_kind     = s_tuser;
    assign status.in_pos_zero = (s_tdata[POS_W-1:0] == '0);
    assign status.short_order = (n_reg < ORDER_W'(3));
    assign status.epoch_full  = &epoch_reg;
    assign status.sweep_last  = (sweep_reg == AW'(MAX_ORDER - 1));
    assign status.eval_last   = (k_reg == n_reg - ORDER_W'(2));
    assign status.out_busy    = out_valid_reg && !m_tready;

    // table ports
    assign rd_addr = cmd.lread ? AW'(val_reg) : AW'(k_reg);
    assign wr_addr = cmd.sweep_en ? sweep_reg : AW'(val_reg);
    assign wr_data = cmd.sweep_en ? '0 : {epoch_reg, pos_reg};
    assign wr_en   = cmd.sweep_en
                   || (cmd.lwrite_force && val_ok)
                   || (cmd.lwrite_cond && val_ok && (!stored_hit || pos_reg < rd_pos));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    // evaluation data stage
    assign present = !d1_oor_reg && stored_hit && ({1'b0, rd_pos} < n_reg);
    assign below_h = (rd_pos < h_reg);
    assign a_next  = a_reg + (below_h ? ACC_W'(n_reg) : '0);
    assign diff    = (e_a_reg >= e_b_reg) ? (e_a_reg - e_b_reg) : (e_b_reg - e_a_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= ORDER_RESET;
            epoch_reg     <= EPOCH_W'(1);
            sweep_reg     <= '0;
            k_reg         <= '0;
            d1_valid_reg  <= 1'b0;
            e_valid_reg   <= 1'b0;
            missing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                n_reg <= cfg_data;

            if (cmd.sweep_en)
                sweep_reg <= status.sweep_last ? '0 : sweep_reg + AW'(1);
            if (cmd.epoch_restart)
                epoch_reg <= EPOCH_W'(1);
            else if (cmd.epoch_step)
                epoch_reg <= epoch_reg + EPOCH_W'(1);

            d1_valid_reg <= cmd.eread;
            e_valid_reg  <= 1'b0;
            if (cmd.take)
            begin
                k_reg       <= '0;
                missing_reg <= 1'b0;
            end
            else
            begin
                if (cmd.eread)
                    k_reg <= k_reg + ORDER_W'(1);
                if (d1_valid_reg && !missing_reg)
                begin
                    if (!present)
                        missing_reg <= 1'b1;
                    else
                        e_valid_reg <= (d1_k_reg != '0);
                end
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pos_reg <= s_tdata[POS_W-1:0];
            val_reg <= s_tdata[2*POS_W-1:POS_W];
            h_reg   <= s_tdata[3*POS_W-1:2*POS_W];
            a_reg   <= '0;
            b_reg   <= ACC_W'({s_tdata[3*POS_W-1:2*POS_W], 1'b0});  // j*h at j = 2
            best_reg   <= '0;
            best_j_reg <= '0;
        end
        else
        begin
            if (d1_valid_reg && !missing_reg && present)
            begin
                a_reg <= a_next;
                if (d1_k_reg != '0)
                begin
                    e_a_reg <= a_next;
                    e_b_reg <= b_reg;
                    e_j_reg <= d1_k_reg + ORDER_W'(1);
                    b_reg   <= b_reg + ACC_W'(h_reg);
                end
            end
            // strict compare keeps the first diagonal that reaches the maximum
            if (e_valid_reg && diff > best_reg)
            begin
                best_reg   <= diff;
                best_j_reg <= e_j_reg;
            end
        end

        d1_k_reg   <= k_reg;
        d1_oor_reg <= (32'(k_reg) >= MAX_ORDER);

        if (cmd.out_load)
        begin
            out_missing_reg <= missing_reg;
            out_j_reg       <= missing_reg ? '0 : best_j_reg[POS_W-1:0];
            if (missing_reg)
                out_dev_reg <= '0;
            else if (best_reg[ACC_W-1])
                out_dev_reg <= DEV_MAX;
            else
                out_dev_reg <= best_reg[DEV_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_missing_reg, out_dev_reg, out_j_reg};

endmodule

/* sv/permutation_diagonal_discrepancy.sv */
// Permutation diagonal discrepancy: maximum scaled deviation of a loaded
// permutation against a split point. Top level; uses pdd_pkg, pdd_ctrl and
// pdd_datapath.
//
// Input stream (s_*): s_tuser = 0 is a load request (position, value), 1 is
// an evaluate request with split point h. Loads give no output; each evaluate
// gives one result on the output stream (m_*). cfg_we/cfg_data set the order
// size n (reset 3); write it only while the block is idle.
// A load at position zero writes its entry directly; any other load reads
// the entry, compares and writes back. An evaluation reads values 0..n-2,
// one table read a cycle, then drains (EDRAIN1, EDRAIN2) and loads the
// result, then takes the next request; with n below 3 no value is read.
// Presence marks are epoch tags: a load at position zero bumps the tag. On
// every 255th such load the table is wiped instead, with s_tready low through
// the wipe and the write of that load. After reset the same wipe runs before
// the first request is taken. A result waits in the output register while
// m_tready is low; the next request is still taken, and a following
// evaluation holds at its end until the register is free.
module permutation_diagonal_discrepancy #(
    parameter int MAX_ORDER = pdd_pkg::MAX_ORDER_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // position [9:0], element_value [19:10], split_point [29:20], zeros [31:30]
    input  logic [pdd_pkg::DATA_W-1:0]    s_tdata,
    // kind [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // best_diagonal [9:0], deviation_scaled [30:10], missing_value [31]
    output logic [pdd_pkg::DATA_W-1:0]    m_tdata,
    input  logic                          cfg_we,
    input  logic [pdd_pkg::ORDER_W-1:0]   cfg_data
);
    import pdd_pkg::*;

    pdd_cmd_t    cmd;
    pdd_status_t status;

    pdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pdd_datapath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

/* sv/pdd_checker.sv */
// Port-level checks for the permutation diagonal discrepancy block, bound to
// the top level. Depends on pdd_pkg for port widths.
module pdd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pdd_pkg::DATA_W-1:0]    m_tdata
);
    import pdd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // every request takes the controller out of idle, so s_tready drops in the cycle after
    a_one_per_visit: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken on two consecutive cycles");

    // missing value forces an all-zero result
    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[DATA_W-1] |-> m_tdata[DATA_W-2:0] == '0)
        else $error("missing value with nonzero result");

    // a zero maximum reports diagonal 0
    a_zero_diag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[DATA_W-2:POS_W] == '0 |-> m_tdata[POS_W-1:0] == '0)
        else $error("zero deviation with nonzero diagonal");

endmodule

bind permutation_diagonal_discrepancy pdd_checker u_pdd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
